// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HEL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: property violated");
`define HEL_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define HEL_ASSERT(label, clk, rst_n, prop)
`define HEL_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/hel_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hel_pkg;

  // Field and datapath widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned LossW    = 18;  // element loss spans -2^15 .. 2^16-1
  localparam int unsigned AccW     = 40;
  localparam int unsigned CntW     = 25;
  localparam int unsigned MaxElements = 16777216;

  // Queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Divider step counter
  localparam int unsigned DivStepW = $clog2(AccW);

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_MARGIN = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MODE   = 1'd1;

  // Reduction modes (code 3 acts as sum)
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_MEAN = 2'd1;
  localparam logic [1:0] MODE_SUM  = 2'd2;

  localparam logic signed [SampleW-1:0] TargetPos   = 16'sd256;
  localparam logic signed [SampleW-1:0] TargetNeg   = -16'sd256;
  localparam logic signed [SampleW-1:0] MarginReset = 16'sd256;

  // What the back end does with a queued element
  typedef enum logic [1:0] {
    KIND_ELEM,
    KIND_ACC,
    KIND_SUM_LAST,
    KIND_MEAN_LAST
  } hel_kind_e;

  typedef struct packed {
    hel_kind_e               kind;
    logic                    last;
    logic signed [LossW-1:0] loss;
  } hel_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hel_fifo_st_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_EMIT
  } hel_state_e;

endpackage

`default_nettype wire

// File: rtl/hel_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hel_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hel_pkg::SampleW-1:0]   sample;
  logic signed [hel_pkg::SampleW-1:0]   target_value;
  logic                                 last_element;

  modport source (output valid, output sample, output target_value, output last_element,
                  input ready);
  modport sink (input valid, input sample, input target_value, input last_element,
                output ready);
endinterface

`default_nettype wire

// File: rtl/hel_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hel_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hel_pkg::AccW-1:0]   loss_out;
  logic                              final_result;

  modport source (output valid, output loss_out, output final_result, input ready);
  modport sink (input valid, input loss_out, input final_result, output ready);
endinterface

`default_nettype wire

// File: rtl/hinge_embedding_loss_core.sv
// Hinge embedding loss with none / mean / sum reduction, signed Q8.8.
// Input channel in_ch carries sample, target_value and last_element; an
// element transfers when valid and ready are both high. Output channel
// out_ch carries loss_out (40-bit Q32.8) and final_result.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 margin, 1 reduction mode) at the clock edge; write only while idle.
// Throughput: one element per cycle while the queue has room. A mean result
// waits for the one-bit-per-cycle restoring divider to run over the 40-bit
// sum after its last element; input keeps flowing into the 4-entry queue meanwhile.
// An element passes the queue entry and the output register before
// out_ch.valid rises; a mean result also passes the ST_DIV and ST_EMIT states.
// Reset (rst_ni low, asynchronous): margin 1.0, mode mean, sum and count
// cleared, queue and output register empty.
// When the receiver stalls the result holds in the output register; sum
// elements keep being consumed until a result is due, then the queue fills
// and in_ch.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module hinge_embedding_loss_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hel_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hel_pkg::CfgDataW-1:0]  cfg_data_i,
  hel_in_if.sink                        in_ch,
  hel_out_if.source                     out_ch
);

  logic                  push, pop;
  hel_pkg::hel_op_t      op_in, op_head;
  hel_pkg::hel_fifo_st_t fifo_st;

  hel_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch),
    .fifo_st_i (fifo_st),
    .push_o    (push),
    .op_o      (op_in)
  );

  hel_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .op_i  (op_in),
    .pop_i (pop),
    .op_o  (op_head),
    .st_o  (fifo_st)
  );

  hel_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fifo_st_i(fifo_st),
    .op_i     (op_head),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/hel_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Front end: holds configuration, computes the element loss and tags each
// element with the action the back end has to take.
module hel_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hel_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hel_pkg::CfgDataW-1:0]  cfg_data_i,
  hel_in_if.sink                        in_ch,
  input  hel_pkg::hel_fifo_st_t         fifo_st_i,
  output logic                          push_o,
  output hel_pkg::hel_op_t              op_o
);

  logic signed [hel_pkg::SampleW-1:0] margin_q, margin_d;
  logic [1:0]                         mode_q, mode_d;
  logic signed [hel_pkg::LossW-1:0]   smp_x, mrg_x, diff, loss;
  hel_pkg::hel_kind_e                 kind;

  // Configuration writes
  always_comb begin
    margin_d = margin_q;
    mode_d   = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hel_pkg::REG_MARGIN: margin_d = cfg_data_i;
        hel_pkg::REG_MODE:   mode_d   = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= hel_pkg::MarginReset;
      mode_q   <= hel_pkg::MODE_MEAN;
    end else begin
      margin_q <= margin_d;
      mode_q   <= mode_d;
    end
  end

  // Element loss
  assign smp_x = hel_pkg::LossW'(in_ch.sample);
  assign mrg_x = hel_pkg::LossW'(margin_q);
  assign diff  = mrg_x - smp_x;

  always_comb begin
    if (in_ch.target_value == hel_pkg::TargetPos) begin
      loss = smp_x;
    end else if (in_ch.target_value == hel_pkg::TargetNeg) begin
      loss = diff[hel_pkg::LossW-1] ? '0 : diff;
    end else begin
      loss = (smp_x > mrg_x) ? smp_x : mrg_x;
    end
  end

  // Classify by mode and last marker
  always_comb begin
    case (mode_q)
      hel_pkg::MODE_NONE: kind = hel_pkg::KIND_ELEM;
      hel_pkg::MODE_MEAN: kind = in_ch.last_element ? hel_pkg::KIND_MEAN_LAST
                                                    : hel_pkg::KIND_ACC;
      default:            kind = in_ch.last_element ? hel_pkg::KIND_SUM_LAST
                                                    : hel_pkg::KIND_ACC;
    endcase
  end

  assign in_ch.ready = !fifo_st_i.full;
  assign push_o      = in_ch.valid && !fifo_st_i.full;
  assign op_o.kind   = kind;
  assign op_o.last   = in_ch.last_element;
  assign op_o.loss   = loss;

endmodule

`default_nettype wire

// File: rtl/hel_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Short queue of tagged elements between front and back end.
module hel_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  hel_pkg::hel_op_t       op_i,
  input  logic                   pop_i,
  output hel_pkg::hel_op_t       op_o,
  output hel_pkg::hel_fifo_st_t  st_o
);

  localparam logic [hel_pkg::FifoCntW-1:0] Full    = hel_pkg::FifoCntW'(hel_pkg::FifoDepth);
  localparam logic [hel_pkg::FifoPtrW-1:0] LastPtr =
    hel_pkg::FifoPtrW'(hel_pkg::FifoDepth - 1);

  hel_pkg::hel_op_t                mem_q [hel_pkg::FifoDepth];
  logic [hel_pkg::FifoPtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [hel_pkg::FifoCntW-1:0]    cnt_q, cnt_d;

  // Pointer and fill update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  assign op_o     = mem_q[rd_q];
  assign st_o.full  = (cnt_q == Full);
  assign st_o.empty = (cnt_q == '0);

  `HEL_ASSERT_NEVER(a_fifo_overfill, clk_i, rst_ni, cnt_q > Full)
  `HEL_ASSERT(a_fifo_pop_nonempty, clk_i, rst_ni, pop_i |-> (cnt_q != '0))

endmodule

`default_nettype wire

// File: rtl/hel_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Back end: saturating accumulate, element count, one-bit-per-cycle
// restoring divider for the mean, and the output register.
module hel_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hel_pkg::hel_fifo_st_t  fifo_st_i,
  input  hel_pkg::hel_op_t       op_i,
  output logic                   pop_o,
  hel_out_if.source              out_ch
);

  localparam int unsigned AccW = hel_pkg::AccW;
  localparam int unsigned CntW = hel_pkg::CntW;
  localparam logic [CntW-1:0] CntMax = CntW'(hel_pkg::MaxElements);
  localparam logic [hel_pkg::DivStepW-1:0] StepLast = hel_pkg::DivStepW'(AccW - 1);
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  hel_pkg::hel_state_e state_q, state_d;

  logic signed [AccW-1:0]        acc_q, acc_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [CntW-1:0]               rem_q, rem_d;
  logic [AccW-1:0]               quo_q, quo_d;
  logic [CntW-1:0]               div_q, div_d;
  logic                          neg_q, neg_d;
  logic [hel_pkg::DivStepW-1:0]  step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [AccW-1:0]        out_loss_q, out_loss_d;
  logic                          out_final_q, out_final_d;

  logic                          out_free, div_run, emit_go, mean_pop;
  logic signed [AccW:0]          sum_wide;
  logic signed [AccW-1:0]        acc_sat;
  logic [CntW-1:0]               cnt_inc;
  logic [CntW:0]                 rem_sh;
  logic [CntW+1:0]               rem_diff;

  assign out_free = !out_valid_q || out_ch.ready;
  assign mean_pop = pop_o && (op_i.kind == hel_pkg::KIND_MEAN_LAST);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hel_pkg::ST_RUN: begin
        if (mean_pop) begin
          state_d = hel_pkg::ST_DIV;
        end
      end
      hel_pkg::ST_DIV: begin
        if (step_q == StepLast) begin
          state_d = hel_pkg::ST_EMIT;
        end
      end
      hel_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = hel_pkg::ST_RUN;
        end
      end
      default: state_d = hel_pkg::ST_RUN;
    endcase
  end

  // State machine outputs; accumulate-only items need no output slot
  always_comb begin
    pop_o   = 1'b0;
    div_run = 1'b0;
    emit_go = 1'b0;
    unique case (state_q)
      hel_pkg::ST_RUN:  pop_o = !fifo_st_i.empty &&
                                (out_free || (op_i.kind == hel_pkg::KIND_ACC));
      hel_pkg::ST_DIV:  div_run = 1'b1;
      hel_pkg::ST_EMIT: emit_go = out_free;
      default: ;
    endcase
  end

  // Saturating add and saturating count
  assign sum_wide = {acc_q[AccW-1], acc_q} + (AccW+1)'(op_i.loss);
  always_comb begin
    if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      acc_sat = sum_wide[AccW] ? AccMin : AccMax;
    end else begin
      acc_sat = sum_wide[AccW-1:0];
    end
  end
  assign cnt_inc = (cnt_q < CntMax) ? cnt_q + 1'b1 : cnt_q;

  // Restoring divider step
  assign rem_sh   = {rem_q, quo_q[AccW-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, div_q};

  // Datapath
  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_d       = div_q;
    neg_d       = neg_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_loss_d  = out_loss_q;
    out_final_d = out_final_q;

    if (pop_o) begin
      case (op_i.kind)
        hel_pkg::KIND_ELEM: begin
          out_valid_d = 1'b1;
          out_loss_d  = AccW'(op_i.loss);
          out_final_d = op_i.last;
        end
        hel_pkg::KIND_ACC: begin
          acc_d = acc_sat;
          cnt_d = cnt_inc;
        end
        hel_pkg::KIND_SUM_LAST: begin
          out_valid_d = 1'b1;
          out_loss_d  = acc_sat;
          out_final_d = 1'b1;
          acc_d       = '0;
          cnt_d       = '0;
        end
        default: begin
          // mean: divide magnitude, fix sign at the end
          acc_d  = '0;
          cnt_d  = '0;
          neg_d  = acc_sat[AccW-1];
          quo_d  = acc_sat[AccW-1] ? -acc_sat : acc_sat;
          div_d  = cnt_inc;
          rem_d  = '0;
          step_d = '0;
        end
      endcase
    end

    if (div_run) begin
      step_d = step_q + 1'b1;
      if (!rem_diff[CntW+1]) begin
        rem_d = rem_diff[CntW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[CntW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b0};
      end
    end

    if (emit_go) begin
      out_valid_d = 1'b1;
      out_loss_d  = neg_q ? -quo_q : quo_q;
      out_final_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hel_pkg::ST_RUN;
      acc_q       <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    div_q       <= div_d;
    neg_q       <= neg_d;
    out_loss_q  <= out_loss_d;
    out_final_q <= out_final_d;
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.loss_out     = out_loss_q;
  assign out_ch.final_result = out_final_q;

  `HEL_ASSERT(a_div_nonzero, clk_i, rst_ni, (state_q == hel_pkg::ST_DIV) |-> (div_q != '0))
  `HEL_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CntMax)
  `HEL_ASSERT(a_mean_start, clk_i, rst_ni, mean_pop |=> (state_q == hel_pkg::ST_DIV))

endmodule

`default_nettype wire
